>>> hdl/assert_macros.svh
// Assertion helper macros for the connection table RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define CHK_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/ftwa_pkg.sv
// Shared types and constants for the connection table with idle timeout.
// No dependencies.
package ftwa_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [31:0] TIMEOUT_RESET = 32'd25;
	localparam logic [15:0] FTP_PORT = 16'd21;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_LOOKUP = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;
	localparam logic [1:0] OP_RSVD   = 2'd3;

	typedef struct packed {
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [31:0] last_seen;
		logic        ftp;
	} flow_t;

	typedef struct packed {
		logic  valid;
		flow_t flow;
	} entry_t;

	typedef enum logic [3:0] {
		MODE_HOLD = 4'b0001,
		MODE_INS  = 4'b0010,
		MODE_LOOK = 4'b0100,
		MODE_CLR  = 4'b1000
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t  mode;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [31:0] now;
		logic [31:0] timeout;
	} cell_ctl_t;

	// Priority chain passed from newer to older cells during a lookup.
	typedef struct packed {
		logic found;
		logic remove;
		logic hit;
		logic ftp;
	} chain_t;

endpackage

>>> hdl/ftwa_cell.sv
// One table slot: holds a flow entry, checks it against the lookup key.
// Depends on ftwa_pkg.
module ftwa_cell import ftwa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  entry_t    left_ent,
	input  entry_t    right_ent,
	output entry_t    ent,
	input  chain_t    chain_in,
	output chain_t    chain_out
);

	logic        valid_q;
	flow_t       flow_q;
	logic [31:0] age;
	logic        expired;
	logic        fwd;
	logic        rev;
	logic        hit;
	logic        first;
	logic        take_right;

	assign ent = '{valid: valid_q, flow: flow_q};

	always_comb begin
		age = ctl.now - flow_q.last_seen;
		expired = valid_q && (age > ctl.timeout);
		fwd = flow_q.src_addr == ctl.src_addr && flow_q.sport == ctl.sport &&
			flow_q.dst_addr == ctl.dst_addr && flow_q.dport == ctl.dport;
		rev = flow_q.src_addr == ctl.dst_addr && flow_q.sport == ctl.dport &&
			flow_q.dst_addr == ctl.src_addr && flow_q.dport == ctl.sport;
		hit = valid_q && !expired && (fwd || rev);
		first = (expired || hit) && !chain_in.found;
		take_right = chain_in.remove || (first && expired);
		chain_out.found = chain_in.found || expired || hit;
		chain_out.remove = chain_in.remove || (first && expired);
		chain_out.hit = chain_in.hit || (first && hit);
		chain_out.ftp = chain_in.ftp || (first && hit && flow_q.ftp);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			unique case (ctl.mode)
				MODE_INS: valid_q <= left_ent.valid;
				MODE_LOOK: begin
					if (take_right) valid_q <= right_ent.valid;
				end
				MODE_CLR: valid_q <= 1'b0;
				default: valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctl.mode)
			MODE_INS: flow_q <= left_ent.flow;
			MODE_LOOK: begin
				if (take_right) begin
					flow_q <= right_ent.flow;
				end else if (first && hit) begin
					flow_q.last_seen <= ctl.now;
				end
			end
			default: flow_q <= flow_q;
		endcase
	end

endmodule

>>> hdl/flow_table_with_aging_core.sv
// Each accepted command is registered and worked on in ST_WORK: insert, clear and the unused code
// give their result beat from there; a lookup first has the cell chain remove each expired entry
// ahead of a match, one per cycle (at most TABLE_DEPTH). One command at a time; busy stays high
// until the result beat, which the receiver cannot stall.
// Reset clears all valid bits, the entry count and loads the timeout register with 25.
// Depends on ftwa_pkg, ftwa_cell and assert_macros.svh.
`include "assert_macros.svh"
module flow_table_with_aging_core import ftwa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             timeout_we,
	input  logic [31:0]      timeout_wdata,
	input  logic             start,
	output logic             busy,
	input  logic [1:0]       operation,
	input  logic [31:0]      src_addr,
	input  logic [31:0]      dst_addr,
	input  logic [15:0]      src_port_num,
	input  logic [15:0]      dst_port_num,
	input  logic [31:0]      now_seconds,
	output logic             done,
	output logic             matched,
	output logic             match_is_ftp,
	output logic             insert_ok,
	output logic [CNT_W-1:0] entries_in_use
);

	// The controller has two states: waiting for a command beat, and working on it.
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WORK = 2'b10
	} state_t;

	state_t           state_q;
	logic [31:0]      timeout_q;
	logic [CNT_W-1:0] count_q;
	logic [1:0]       op_q;
	logic [31:0]      sa_q;
	logic [31:0]      da_q;
	logic [15:0]      sp_q;
	logic [15:0]      dp_q;
	logic [31:0]      now_q;
	logic             done_q;
	logic             matched_q;
	logic             ftp_q;
	logic             ins_ok_q;

	cell_ctl_t ctl;
	entry_t    ents [TABLE_DEPTH];
	chain_t    chain [TABLE_DEPTH+1];
	entry_t    new_ent;
	entry_t    empty_ent;
	logic      table_full;

	assign busy = (state_q != ST_IDLE);
	assign table_full = (count_q == CNT_W'(TABLE_DEPTH));

	// Entry that enters at the front of the chain on an insert.
	assign new_ent = '{valid: 1'b1, flow: '{src_addr: sa_q, dst_addr: da_q,
		sport: sp_q, dport: dp_q, last_seen: now_q, ftp: (dp_q == FTP_PORT)}};
	assign empty_ent = '0;
	assign chain[0] = '0;

	// Broadcast command to every cell; cells act only in the working state.
	always_comb begin
		ctl.mode = MODE_HOLD;
		if (state_q == ST_WORK) begin
			unique case (op_q)
				OP_INSERT: ctl.mode = table_full ? MODE_HOLD : MODE_INS;
				OP_LOOKUP: ctl.mode = MODE_LOOK;
				OP_CLEAR:  ctl.mode = MODE_CLR;
				default:   ctl.mode = MODE_HOLD;
			endcase
		end
		ctl.src_addr = sa_q;
		ctl.dst_addr = da_q;
		ctl.sport = sp_q;
		ctl.dport = dp_q;
		ctl.now = now_q;
		ctl.timeout = timeout_q;
	end

	// Slot 0 is the newest; an insert shifts toward higher slots, a removal
	// pulls everything behind the removed slot one place toward the front.
	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		ftwa_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.left_ent  ((g == 0) ? new_ent : ents[(g == 0) ? 0 : g-1]),
			.right_ent ((g == TABLE_DEPTH-1) ? empty_ent
				: ents[(g == TABLE_DEPTH-1) ? g : g+1]),
			.ent       (ents[g]),
			.chain_in  (chain[g]),
			.chain_out (chain[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (timeout_we) begin
			timeout_q <= timeout_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_q <= operation;
			sa_q <= src_addr;
			da_q <= dst_addr;
			sp_q <= src_port_num;
			dp_q <= dst_port_num;
			now_q <= now_seconds;
		end
	end

	// A lookup stays in the working state while the scan keeps finding an
	// expired entry ahead of any match; each such cycle removes one entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			done_q <= 1'b0;
			matched_q <= 1'b0;
			ftp_q <= 1'b0;
			ins_ok_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) state_q <= ST_WORK;
				end
				ST_WORK: begin
					matched_q <= 1'b0;
					ftp_q <= 1'b0;
					ins_ok_q <= 1'b0;
					case (op_q)
						OP_INSERT: begin
							if (!table_full) begin
								count_q <= count_q + CNT_W'(1);
								ins_ok_q <= 1'b1;
							end
							done_q <= 1'b1;
							state_q <= ST_IDLE;
						end
						OP_LOOKUP: begin
							if (chain[TABLE_DEPTH].remove) begin
								count_q <= count_q - CNT_W'(1);
							end else begin
								matched_q <= chain[TABLE_DEPTH].hit;
								ftp_q <= chain[TABLE_DEPTH].ftp;
								done_q <= 1'b1;
								state_q <= ST_IDLE;
							end
						end
						OP_CLEAR: begin
							count_q <= '0;
							done_q <= 1'b1;
							state_q <= ST_IDLE;
						end
						default: begin
							done_q <= 1'b1;
							state_q <= ST_IDLE;
						end
					endcase
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign matched = matched_q;
	assign match_is_ftp = ftp_q;
	assign insert_ok = ins_ok_q;
	assign entries_in_use = count_q;

	`CHK_ALWAYS(a_count_bound, clk, arst_n, count_q <= CNT_W'(TABLE_DEPTH), "entry count beyond depth")
	`CHK_ALWAYS(a_flags_excl, clk, arst_n, !(insert_ok && matched), "insert and match both set")
	`CHK_NEXT(a_done_from_work, clk, arst_n, !busy, !done, "result beat without work")

endmodule

>>> tb/flow_table_with_aging_core_tb.sv
// Self-checking testbench for the connection table with idle timeout.
// Depends on ftwa_pkg and flow_table_with_aging_core; needs nothing else.
module flow_table_with_aging_core_tb;
	import ftwa_pkg::*;

	// Scoreboard: a behavioral copy of the connection table that predicts the
	// result beat of each accepted command and checks the beats that come back.
	class flow_scoreboard;
		flow_t       flows[$];          // index 0 is the newest entry
		logic [31:0] timeout;
		bit          exp_matched[$];
		bit          exp_ftp[$];
		bit          exp_ins_ok[$];
		int          exp_count[$];
		int          mismatches;
		int          beats_checked;

		function new();
			timeout = TIMEOUT_RESET;
		endfunction

		// Applies one accepted command to the table copy and queues its result.
		function void note_command(logic [1:0] op, logic [31:0] sa, logic [31:0] da,
				logic [15:0] sp, logic [15:0] dp, logic [31:0] now);
			flow_t f;
			bit hit, ftp, ok;
			int i;
			logic [31:0] age;
			hit = 0;
			ftp = 0;
			ok = 0;
			if (op == OP_INSERT) begin
				if (flows.size() < TABLE_DEPTH) begin
					f.src_addr = sa;
					f.dst_addr = da;
					f.sport = sp;
					f.dport = dp;
					f.last_seen = now;
					f.ftp = (dp == FTP_PORT);
					flows.push_front(f);
					ok = 1;
				end
			end else if (op == OP_LOOKUP) begin
				i = 0;
				while (i < flows.size()) begin
					age = now - flows[i].last_seen;
					if (age > timeout) begin
						flows.delete(i);
					end else if ((flows[i].src_addr == sa && flows[i].sport == sp &&
							flows[i].dst_addr == da && flows[i].dport == dp) ||
							(flows[i].src_addr == da && flows[i].sport == dp &&
							flows[i].dst_addr == sa && flows[i].dport == sp)) begin
						flows[i].last_seen = now;
						hit = 1;
						ftp = flows[i].ftp;
						break;
					end else begin
						i++;
					end
				end
			end else if (op == OP_CLEAR) begin
				flows.delete();
			end
			exp_matched.push_back(hit);
			exp_ftp.push_back(ftp);
			exp_ins_ok.push_back(ok);
			exp_count.push_back(flows.size());
		endfunction

		function void report(string what);
			$display("MISMATCH at %0t: %s", $time, what);
			mismatches++;
		endfunction

		// Compares one result beat against the oldest prediction.
		function void check_beat(bit m, bit fp, bit ok, int cnt);
			if (exp_count.size() == 0) begin
				report("result beat with nothing expected");
				return;
			end
			beats_checked++;
			if (m != exp_matched[0])
				report($sformatf("matched %0b expected %0b", m, exp_matched[0]));
			if (fp != exp_ftp[0])
				report($sformatf("match_is_ftp %0b expected %0b", fp, exp_ftp[0]));
			if (ok != exp_ins_ok[0])
				report($sformatf("insert_ok %0b expected %0b", ok, exp_ins_ok[0]));
			if (cnt != exp_count[0])
				report($sformatf("entries_in_use %0d expected %0d", cnt, exp_count[0]));
			void'(exp_matched.pop_front());
			void'(exp_ftp.pop_front());
			void'(exp_ins_ok.pop_front());
			void'(exp_count.pop_front());
		endfunction

		function int pending();
			return exp_count.size();
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             timeout_we;
	logic [31:0]      timeout_wdata;
	logic             start;
	logic             busy;
	logic [1:0]       operation;
	logic [31:0]      src_addr;
	logic [31:0]      dst_addr;
	logic [15:0]      src_port_num;
	logic [15:0]      dst_port_num;
	logic [31:0]      now_seconds;
	logic             done;
	logic             matched;
	logic             match_is_ftp;
	logic             insert_ok;
	logic [CNT_W-1:0] entries_in_use;

	flow_table_with_aging_core dut (
		.clk(clk), .arst_n(arst_n),
		.timeout_we(timeout_we), .timeout_wdata(timeout_wdata),
		.start(start), .busy(busy), .operation(operation),
		.src_addr(src_addr), .dst_addr(dst_addr),
		.src_port_num(src_port_num), .dst_port_num(dst_port_num),
		.now_seconds(now_seconds), .done(done), .matched(matched),
		.match_is_ftp(match_is_ftp), .insert_ok(insert_ok),
		.entries_in_use(entries_in_use)
	);

	flow_scoreboard sb;
	logic [31:0]    clock_now;      // running time stamp for generated traffic
	bit             steady_phase;   // no idle cycles while set
	int             commands_sent;
	int             lookup_hits;
	int             full_rejects;
	flow_t          known[$];       // pool of flows used to build lookups that hit

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// Watchdog: far above the slowest correct run of roughly 2000 commands,
	// each with its scan and random gaps.
	initial begin
		#2000000;
		$display("flow_table_with_aging_core_tb: done, errors");
		$finish;
	end

	// Every result beat is accepted at the rising edge that ends its cycle.
	always @(posedge clk) begin
		if (arst_n && done) begin
			sb.check_beat(matched, match_is_ftp, insert_ok, entries_in_use);
			if (matched)
				lookup_hits++;
		end
	end

	// Sends one command beat. Inputs move on the falling edge; the beat is
	// accepted at the rising edge where start is high and busy is low. The
	// first falling edge keeps the drop of start from the previous beat apart
	// from the next rise; the block is still busy then, so no rate is lost.
	task automatic send_command(logic [1:0] op, logic [31:0] sa, logic [31:0] da,
			logic [15:0] sp, logic [15:0] dp, logic [31:0] now);
		bit accepted;
		@(negedge clk);
		while (!steady_phase && $urandom_range(99) < 27) begin
			@(negedge clk);
		end
		start <= 1;
		operation <= op;
		src_addr <= sa;
		dst_addr <= da;
		src_port_num <= sp;
		dst_port_num <= dp;
		now_seconds <= now;
		accepted = 0;
		while (!accepted) begin
			@(posedge clk);
			accepted = !busy;
		end
		if (op == OP_INSERT && sb.flows.size() >= TABLE_DEPTH)
			full_rejects++;
		sb.note_command(op, sa, da, sp, dp, now);
		commands_sent++;
		@(negedge clk);
		start <= 0;
	endtask

	// Waits out every expected beat plus the longest scan, before a register write or the end of the run.
	task automatic drain();
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (TABLE_DEPTH + 8) @(negedge clk);
	endtask

	task automatic write_timeout(logic [31:0] value);
		drain();
		timeout_we <= 1;
		timeout_wdata <= value;
		@(negedge clk);
		timeout_we <= 0;
		sb.timeout = value;
	endtask

	// Random flow with small address and port pools so lookups and reverse
	// matches collide often; occasionally full-range values and port 21.
	function automatic flow_t random_flow();
		flow_t f;
		if ($urandom_range(9) == 0) begin
			f.src_addr = $urandom;
			f.dst_addr = $urandom;
			f.sport = 16'($urandom);
			f.dport = 16'($urandom);
		end else begin
			f.src_addr = 32'h0A00_0000 | $urandom_range(3);
			f.dst_addr = 32'h0A00_0000 | $urandom_range(3);
			f.sport = $urandom_range(3) == 0 ? FTP_PORT
				: 16'd1000 + 16'($urandom_range(3));
			f.dport = $urandom_range(3) == 0 ? FTP_PORT
				: 16'd1000 + 16'($urandom_range(3));
		end
		f.last_seen = 0;
		f.ftp = 0;
		return f;
	endfunction

	// One random command; time steps forward by a little so entries age out.
	task automatic random_command();
		flow_t f;
		int pick;
		logic [1:0] op;
		pick = $urandom_range(99);
		clock_now = clock_now + $urandom_range(6);
		if (pick < 40) begin
			f = random_flow();
			known.push_back(f);
			if (known.size() > 40)
				void'(known.pop_front());
			send_command(OP_INSERT, f.src_addr, f.dst_addr, f.sport, f.dport,
				clock_now);
		end else if (pick < 85 && known.size() > 0) begin
			f = known[$urandom_range(known.size() - 1)];
			if ($urandom_range(1))
				send_command(OP_LOOKUP, f.dst_addr, f.src_addr, f.dport, f.sport,
					clock_now);
			else
				send_command(OP_LOOKUP, f.src_addr, f.dst_addr, f.sport, f.dport,
					clock_now);
		end else if (pick < 95) begin
			f = random_flow();
			send_command(OP_LOOKUP, f.src_addr, f.dst_addr, f.sport, f.dport,
				clock_now);
		end else begin
			op = (pick < 98) ? OP_CLEAR : OP_RSVD;
			send_command(op, $urandom, $urandom, 16'($urandom), 16'($urandom), clock_now);
		end
	endtask

	initial begin
		int i;
		sb = new();
		arst_n = 0;
		timeout_we = 0;
		timeout_wdata = 0;
		start = 0;
		operation = OP_INSERT;
		src_addr = 0;
		dst_addr = 0;
		src_port_num = 0;
		dst_port_num = 0;
		now_seconds = 0;
		clock_now = 100;
		steady_phase = 0;
		commands_sent = 0;
		lookup_hits = 0;
		full_rejects = 0;
		repeat (7) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed part, reset timeout of 25.
		// Lookup and clear on an empty table, and the unused operation code.
		send_command(OP_LOOKUP, 32'hFFFF_FFFF, 0, 16'hFFFF, 0, 32'hFFFF_FFFF);
		send_command(OP_CLEAR, 0, 0, 0, 0, 0);
		send_command(OP_RSVD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
		// Extremes of every field, an FTP entry and a flow near the time wrap.
		send_command(OP_INSERT, 32'hFFFF_FFFF, 0, 16'hFFFF, FTP_PORT, 32'hFFFF_FFF0);
		send_command(OP_INSERT, 0, 32'hFFFF_FFFF, 0, 16'hFFFF, 32'hFFFF_FFF0);
		// Forward and reverse hits across the wrap of the time counter.
		send_command(OP_LOOKUP, 32'hFFFF_FFFF, 0, 16'hFFFF, FTP_PORT, 32'h0000_0005);
		send_command(OP_LOOKUP, 32'hFFFF_FFFF, 0, 16'hFFFF, 0, 32'h0000_0006);
		// Age exactly at the timeout stays, one beyond it expires.
		send_command(OP_LOOKUP, 0, FTP_PORT, 0, 0, 32'h0000_0009);
		send_command(OP_LOOKUP, 0, 0, 0, 0, 32'h0000_001F);
		send_command(OP_LOOKUP, 1, 2, 3, 4, 32'h0000_0040);
		// Fill the table past its depth to see the full rejection.
		for (i = 0; i < TABLE_DEPTH + 2; i++)
			send_command(OP_INSERT, i, ~i, 16'(i), 16'd21 + 16'(i[0]), 32'd500);
		send_command(OP_LOOKUP, 5, ~32'd5, 5, 16'd22, 32'd510);
		// A late lookup sweeps every expired entry out in one scan.
		send_command(OP_LOOKUP, 7, 7, 7, 7, 32'd900);

		// Zero timeout: anything not seen in this very second expires.
		write_timeout(0);
		send_command(OP_INSERT, 1, 2, 3, FTP_PORT, 32'd1000);
		send_command(OP_LOOKUP, 2, 1, FTP_PORT, 3, 32'd1000);
		send_command(OP_LOOKUP, 1, 2, 3, FTP_PORT, 32'd1001);

		// Largest timeout: nothing ever expires.
		write_timeout(32'hFFFF_FFFF);
		send_command(OP_INSERT, 9, 8, 7, 6, 32'd0);
		send_command(OP_LOOKUP, 9, 8, 7, 6, 32'hFFFF_FFFF);
		send_command(OP_CLEAR, 0, 0, 0, 0, 0);

		// Random part in phases with different timeouts; one stretch runs
		// without any idle cycles.
		for (i = 0; i < 1850; i++) begin
			if (i % 370 == 0) begin
				case ((i / 370) % 5)
					0: write_timeout(TIMEOUT_RESET);
					1: write_timeout(3);
					2: write_timeout(60);
					3: write_timeout(0);
					default: write_timeout($urandom_range(8, 40));
				endcase
				clock_now = (i / 370 == 3) ? 32'hFFFF_FF00 : clock_now;
			end
			steady_phase = (i >= 600 && i < 900);
			random_command();
		end

		// Let the last beat and any trailing scan finish.
		drain();
		$display("Covered %0d commands, %0d lookup hits, %0d inserts rejected on a full table.",
			commands_sent, lookup_hits, full_rejects);
		$display("Result beats checked: %0d, mismatches: %0d.", sb.beats_checked,
			sb.mismatches);
		if (sb.mismatches == 0)
			$display("flow_table_with_aging_core_tb: done, clean");
		else
			$display("flow_table_with_aging_core_tb: done, errors");
		$finish;
	end
endmodule

>>> filelist.f
+incdir+hdl
hdl/ftwa_pkg.sv
hdl/ftwa_cell.sv
hdl/flow_table_with_aging_core.sv
tb/flow_table_with_aging_core_tb.sv
